### rtl/core/vn_pkg.sv
// Shared constants for the vector normalizer.
package vn_pkg;
   localparam int unsigned IN_WIDTH_DEF = 16;
   localparam int unsigned OUT_FRAC_DEF = 14;
   localparam int unsigned LANES = 3;
endpackage

### rtl/core/vn_lane.sv
// One lane: restoring search for the unit magnitude of one component,
// one quotient bit per pipeline stage.
module vn_lane import vn_pkg::*; #(
   parameter int unsigned IN_WIDTH = IN_WIDTH_DEF,
   parameter int unsigned OUT_FRAC = OUT_FRAC_DEF,
   localparam int unsigned MW = IN_WIDTH,
   localparam int unsigned SW = 2 * IN_WIDTH + 2,
   localparam int unsigned QW = OUT_FRAC + 1,
   localparam int unsigned TW = 2 * MW + 2 * OUT_FRAC,
   localparam int unsigned LW = 2 * QW + SW
) (
   input  logic          clock,
   input  logic          in_en,
   input  logic [MW-1:0] in_mag,
   input  logic [SW-1:0] in_sum,
   output logic [QW-1:0] out_q
);
   logic [TW-1:0] tgt_ff  [QW];
   logic [SW-1:0] sum_ff  [QW];
   logic [LW-1:0] sq_ff   [QW];
   logic [LW-1:0] lin_ff  [QW];
   logic [QW-1:0] q_ff    [QW+1];
   logic [LW-1:0] sq_try  [QW];
   logic [LW-1:0] lin_try [QW-1];
   logic          take    [QW];
   logic [TW-1:0] tgt_in;

   assign tgt_in = TW'(in_mag) * TW'(in_mag) << (2 * OUT_FRAC);

   // Try the next bit: (q + 2^b)^2 * sum = q*q*sum + 2^(b+1)*q*sum + 2^(2b)*sum,
   // so the running products advance by shifts and adds only.
   always_comb begin
      for (int j = 0; j < QW; j++) begin
         sq_try[j] = sq_ff[j] + (lin_ff[j] << (QW - j))
                     + (LW'(sum_ff[j]) << (2 * (QW - 1 - j)));
         take[j]   = sq_try[j] <= LW'(tgt_ff[j]);
      end
      for (int j = 0; j < QW - 1; j++) begin
         lin_try[j] = lin_ff[j] + (LW'(sum_ff[j]) << (QW - 1 - j));
      end
   end

   // Stage 0 loads the target; stage j+1 decides bit QW-1-j.
   always_ff @(posedge clock) begin
      if (in_en) begin
         tgt_ff[0] <= tgt_in;
         sum_ff[0] <= in_sum;
         sq_ff[0]  <= '0;
         lin_ff[0] <= '0;
         q_ff[0]   <= '0;
         for (int j = 0; j < QW; j++) begin
            q_ff[j+1] <= take[j] ? (q_ff[j] | (QW'(1) << (QW - 1 - j))) : q_ff[j];
         end
         for (int j = 1; j < QW; j++) begin
            tgt_ff[j] <= tgt_ff[j-1];
            sum_ff[j] <= sum_ff[j-1];
            sq_ff[j]  <= take[j-1] ? sq_try[j-1] : sq_ff[j-1];
            lin_ff[j] <= take[j-1] ? lin_try[j-1] : lin_ff[j-1];
         end
      end
   end

   assign out_q = q_ff[QW];
endmodule

### rtl/core/vector3_normalize.sv
// Top level of the three-lane vector normalizer.
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_vec_x/y/z
// rsp     | out       | rsp_valid, rsp_ready, rsp_unit_x/y/z, rsp_zero_vector
// One transaction per cycle while no finished result is stalled; each result passes
// through the per-bit stages of each lane's magnitude search.
// Reset clears all stage valid bits. A stalled result holds the whole pipeline.
module vector3_normalize import vn_pkg::*; #(
   parameter int unsigned IN_WIDTH = IN_WIDTH_DEF,
   parameter int unsigned OUT_FRAC = OUT_FRAC_DEF,
   localparam int unsigned QW = OUT_FRAC + 1,
   localparam int unsigned OW = OUT_FRAC + 2,
   localparam int unsigned SW = 2 * IN_WIDTH + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [IN_WIDTH-1:0] req_vec_x,
   input  logic signed [IN_WIDTH-1:0] req_vec_y,
   input  logic signed [IN_WIDTH-1:0] req_vec_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OW-1:0]       rsp_unit_x,
   output logic signed [OW-1:0]       rsp_unit_y,
   output logic signed [OW-1:0]       rsp_unit_z,
   output logic                       rsp_zero_vector
);
   logic [QW:0] vld_ff, vld_in;
   logic [QW:0] sgn_ff [LANES];
   logic [QW:0] zero_ff;
   logic        adv;
   logic [IN_WIDTH-1:0] mag [LANES];
   logic [IN_WIDTH-1:0] raw [LANES];
   logic [SW-1:0] sum;
   logic [QW-1:0] q [LANES];
   logic [OW-1:0] res [LANES];

   assign raw[0] = req_vec_x;
   assign raw[1] = req_vec_y;
   assign raw[2] = req_vec_z;

   // Stall everything while a finished result waits.
   assign adv       = !vld_ff[QW] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[QW-1:0], req_valid};

   always_comb begin
      sum = '0;
      for (int i = 0; i < LANES; i++) begin
         mag[i] = raw[i][IN_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
         sum = sum + SW'(mag[i]) * SW'(mag[i]);
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vn_lane #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC(OUT_FRAC)) u_lane (
         .clock(clock), .in_en(adv), .in_mag(mag[i]),
         .in_sum(sum), .out_q(q[i]));
      // Merge: apply sign, force zero.
      assign res[i] = zero_ff[QW] ? '0 :
                      sgn_ff[i][QW] ? (~OW'(q[i]) + 1'b1) : OW'(q[i]);
   end

   // Carry the signs alongside the lanes.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            sgn_ff[i] <= {sgn_ff[i][QW-1:0], raw[i][IN_WIDTH-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) zero_ff <= {zero_ff[QW-1:0], sum == '0};
   end

   // Advance the valid bits.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   assign rsp_valid       = vld_ff[QW];
   assign rsp_unit_x      = res[0];
   assign rsp_unit_y      = res[1];
   assign rsp_unit_z      = res[2];
   assign rsp_zero_vector = zero_ff[QW];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_x))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_unit_x == '0 && rsp_unit_z == '0)
      else $error("zero vector with nonzero output");
endmodule

### tb/testbench.sv
// Self-checking regression for the three-lane vector normalizer.
module testbench;
   import vn_pkg::*;

   localparam int unsigned IW = IN_WIDTH_DEF;
   localparam int unsigned OF = OUT_FRAC_DEF;
   localparam int unsigned OW = OF + 2;
   localparam int unsigned LATENCY = OF + 1;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [OW-1:0] ux;
      logic signed [OW-1:0] uy;
      logic signed [OW-1:0] uz;
      logic                 zero;
   } unit_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IW-1:0] req_vec_x = '0;
   logic signed [IW-1:0] req_vec_y = '0;
   logic signed [IW-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OW-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_zero_vector;

   unit_vec_type expected_units[$];
   int errors = 0;
   longint cycles = 0;

   vector3_normalize u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_zero_vector(rsp_zero_vector)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Abort on a stuck run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("vector3_normalize regression: fail");
         $finish;
      end
   end

   // Largest q with q*q*sum <= c*c*2^(2*OF)
   function automatic logic [OF:0] unit_magnitude(logic [IW:0] c, logic [2*IW+1:0] sum);
      logic [127:0] target;
      logic [127:0] lhs;
      logic [OF:0] q;
      logic [OF:0] t;
      target = (128'(c) * 128'(c)) << (2 * OF);
      q = '0;
      for (int b = OF; b >= 0; b--) begin
         t = q | ((OF+1)'(1) << b);
         lhs = 128'(t) * 128'(t) * 128'(sum);
         if (lhs <= target) q = t;
      end
      return q;
   endfunction

   function automatic unit_vec_type normalize_vec(logic signed [IW-1:0] x,
         logic signed [IW-1:0] y, logic signed [IW-1:0] z);
      logic [IW:0] mag[3];
      logic signed [IW-1:0] comp[3];
      logic [2*IW+1:0] sum;
      logic signed [OW-1:0] u[3];
      unit_vec_type r;
      comp[0] = x; comp[1] = y; comp[2] = z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = comp[i][IW-1] ? (IW+1)'(-$signed({comp[i][IW-1], comp[i]}))
                                : (IW+1)'(comp[i]);
         sum += mag[i] * mag[i];
      end
      if (sum == 0) begin
         r = '{ux: '0, uy: '0, uz: '0, zero: 1'b1};
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         u[i] = OW'(unit_magnitude(mag[i], sum));
         if (comp[i][IW-1]) u[i] = -u[i];
      end
      r = '{ux: u[0], uy: u[1], uz: u[2], zero: 1'b0};
      return r;
   endfunction

   // Send one transaction, after a random gap when gaps is set
   task automatic send_vec(logic signed [IW-1:0] x, logic signed [IW-1:0] y,
         logic signed [IW-1:0] z, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      expected_units.insert(expected_units.size(), normalize_vec(x, y, z));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            $display("%0t: unexpected result %h %h %h %b", $time,
               rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_zero_vector);
            errors++;
         end else begin
            want = expected_units.pop_front();
            if (want.ux !== rsp_unit_x) begin
               $display("%0t: unit_x exp %0d got %0d", $time, want.ux, rsp_unit_x);
               errors++;
            end
            if (want.uy !== rsp_unit_y) begin
               $display("%0t: unit_y exp %0d got %0d", $time, want.uy, rsp_unit_y);
               errors++;
            end
            if (want.uz !== rsp_unit_z) begin
               $display("%0t: unit_z exp %0d got %0d", $time, want.uz, rsp_unit_z);
               errors++;
            end
            if (want.zero !== rsp_zero_vector) begin
               $display("%0t: zero_vector exp %b got %b", $time, want.zero,
                  rsp_zero_vector);
               errors++;
            end
         end
      end
   end

   // Receiver stalls: random hold-off per result, with stall-free stretches
   initial begin
      int stall;
      forever begin
         stall = ((cycles / 3000) % 3 == 1) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic test_extremes();
      logic signed [IW-1:0] mx, mn;
      mx = {1'b0, {(IW-1){1'b1}}};
      mn = {1'b1, {(IW-1){1'b0}}};
      send_vec(0, 0, 0);
      send_vec(1, 0, 0);
      send_vec(0, -1, 0);
      send_vec(0, 0, mn);
      send_vec(mx, 0, 0);
      send_vec(mn, 0, 0);
      send_vec(0, mx, 0);
      send_vec(0, 0, -1);
      send_vec(mx, mx, mx);
      send_vec(mn, mn, mn);
      send_vec(mn, mx, mn);
      send_vec(1, 1, 1);
      send_vec(-1, -1, -1);
      send_vec(256, 256, 0);
      send_vec(mx, 1, -1);
      send_vec(3, -4, 0);
      send_vec(0, 0, 0);
   endtask

   task automatic wait_drained();
      idle_sender();
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   task automatic test_random(int count);
      logic signed [IW-1:0] v[3];
      int mode;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 3; i++) begin
            mode = $urandom_range(0, 9);
            case (mode)
               0: v[i] = '0;
               1: v[i] = IW'($signed($urandom_range(0, 16)) - 8);
               2: v[i] = {1'b1, {(IW-1){1'b0}}};
               default: v[i] = IW'($urandom);
            endcase
         end
         if ($urandom_range(0, 29) == 0) v = '{0, 0, 0};
         send_vec(v[0], v[1], v[2], !((n / 200) % 4 == 2));
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      wait_drained();
      test_random(1400);
      wait_drained();
      repeat (LATENCY * 2) @(posedge clock);
      if (errors == 0 && expected_units.size() == 0)
         $display("vector3_normalize regression: pass");
      else
         $display("vector3_normalize regression: fail");
      $finish;
   end
endmodule

### files.f
rtl/core/vn_pkg.sv
rtl/core/vn_lane.sv
rtl/core/vector3_normalize.sv
tb/testbench.sv
